// ===== hdl/ytc_pkg.sv =====
// ytc_pkg: shared types, register indexes, reset values and the angle wrap
// helper for the yaw turn controller. No dependencies.
package ytc_pkg;

  typedef logic signed [12:0] angle_t;   // heading, 1/16 degree
  typedef logic signed [13:0] turn_t;    // relative turn request
  typedef logic signed [8:0]  drive_t;   // motor command
  typedef logic signed [16:0] wide_t;    // headroom for sums before wrap

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_MS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DRIVE = 3'd4;

  // reset values
  localparam logic [11:0] TOLERANCE_RST = 12'd32;
  localparam logic [15:0] WAIT_MS_RST   = 16'd2000;
  localparam logic [7:0]  GAIN_RST      = 8'd40;
  localparam logic [7:0]  MAX_DRIVE_RST = 8'd120;
  localparam logic [7:0]  MIN_DRIVE_RST = 8'd45;

  // request action codes
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  localparam wide_t FULL_TURN = 17'sd5760;
  localparam wide_t HALF_TURN = 17'sd2880;

  // Wrap into [-HALF_TURN, HALF_TURN). Inputs stay within two turns of
  // the window, so five candidate offsets cover every case.
  function automatic angle_t wrap_angle(input wide_t v);
    wide_t r;
    if (v >= HALF_TURN + FULL_TURN)
      r = v - (FULL_TURN + FULL_TURN);
    else if (v >= HALF_TURN)
      r = v - FULL_TURN;
    else if (v >= -HALF_TURN)
      r = v;
    else if (v >= -HALF_TURN - FULL_TURN)
      r = v + FULL_TURN;
    else
      r = v + (FULL_TURN + FULL_TURN);
    return r[12:0];
  endfunction

endpackage

// ===== hdl/ytc_in_if.sv =====
// ytc_in_if: request channel of the yaw turn controller (valid/ready).
// Depends on ytc_pkg.
interface ytc_in_if;
  logic            valid;
  logic            ready;
  logic            action;
  ytc_pkg::angle_t yaw;
  ytc_pkg::turn_t  turn_angle;
  logic [31:0]     now_ms;

  modport source (output valid, action, yaw, turn_angle, now_ms, input ready);
  modport sink   (input valid, action, yaw, turn_angle, now_ms, output ready);
endinterface

// ===== hdl/ytc_out_if.sv =====
// ytc_out_if: result channel of the yaw turn controller (valid/ready).
// Depends on ytc_pkg.
interface ytc_out_if;
  logic            valid;
  logic            ready;
  ytc_pkg::drive_t left_drive;
  ytc_pkg::drive_t right_drive;
  logic            done_res;

  modport source (output valid, left_drive, right_drive, done_res, input ready);
  modport sink   (input valid, left_drive, right_drive, done_res, output ready);
endinterface

// ===== hdl/ytc_drive_calc.sv =====
// ytc_drive_calc: proportional drive from the heading error: scale,
// truncate toward zero, clamp, then raise to the friction floor.
// Depends on ytc_pkg.
module ytc_drive_calc (
  input  ytc_pkg::angle_t err,
  input  logic [7:0]      gain,
  input  logic [7:0]      max_drive,
  input  logic [7:0]      min_drive,
  output ytc_pkg::drive_t drive
);

  logic signed [21:0] prod;
  logic signed [21:0] biased;
  logic signed [13:0] quot;
  logic signed [13:0] maxd;
  logic signed [13:0] mind;
  logic signed [13:0] clamped;
  logic signed [13:0] mag;
  logic signed [13:0] raised;

  always_comb begin
    // widen both operands first so the product keeps all its bits
    prod   = signed'(22'(gain)) * 22'(err);
    // bias negatives so the shift truncates toward zero
    biased = prod + (prod[21] ? 22'sd255 : 22'sd0);
    quot   = biased[21:8];
    maxd   = signed'({6'b0, max_drive});
    mind   = signed'({6'b0, min_drive});

    if (quot > maxd)
      clamped = maxd;
    else if (quot < -maxd)
      clamped = -maxd;
    else
      clamped = quot;

    mag = clamped[13] ? -clamped : clamped;
    if (mag < mind)
      raised = (err > 13'sd0) ? mind : -mind;
    else
      raised = clamped;

    drive = raised[8:0];
  end

endmodule

// ===== hdl/yaw_turn_controller.sv =====
// yaw_turn_controller: top level of the in-place proportional turn
// controller. Depends on ytc_pkg, ytc_in_if, ytc_out_if, ytc_drive_calc.
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        action, yaw, turn_angle, now_ms
//  out_ch   out  valid/ready        left_drive, right_drive, done_res
//  cfg_*    in   cfg_we (no ready)  cfg_index, cfg_wdata
//
// One request per cycle while the result side keeps up. A request is held in
// the input register, the heading/drive logic works on it there, and the
// result register takes the answer when the input register hands it on.
// Start requests update the target and leave no result.
// Reset (rst_n low, synchronous) clears the flags, target, wait start time and
// valid bits and reloads the register defaults.
// A stalled result blocks the input register only when that register
// holds an update; an empty input register still takes one request while it waits.
module yaw_turn_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  ytc_in_if.sink                             in_ch,
  ytc_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [ytc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ytc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // ---------------- configuration registers ----------------
  logic [11:0] tolerance_r;
  logic [15:0] wait_ms_r;
  logic [7:0]  gain_r;
  logic [7:0]  max_drive_r;
  logic [7:0]  min_drive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r <= ytc_pkg::TOLERANCE_RST;
      wait_ms_r   <= ytc_pkg::WAIT_MS_RST;
      gain_r      <= ytc_pkg::GAIN_RST;
      max_drive_r <= ytc_pkg::MAX_DRIVE_RST;
      min_drive_r <= ytc_pkg::MIN_DRIVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ytc_pkg::REG_TOLERANCE: tolerance_r <= cfg_wdata[11:0];
        ytc_pkg::REG_WAIT_MS:   wait_ms_r   <= cfg_wdata;
        ytc_pkg::REG_GAIN:      gain_r      <= cfg_wdata[7:0];
        ytc_pkg::REG_MAX_DRIVE: max_drive_r <= cfg_wdata[7:0];
        ytc_pkg::REG_MIN_DRIVE: min_drive_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  logic            s1_v_r;
  logic            s1_act_r;
  ytc_pkg::angle_t s1_yaw_r;
  ytc_pkg::turn_t  s1_ang_r;
  logic [31:0]     s1_now_r;

  logic out_v_r;
  logic s1_move;     // input register hands its request on this edge
  logic in_fire;

  // a start needs no result slot; an update needs a free or draining one
  assign s1_move  = s1_v_r && ((s1_act_r == ytc_pkg::ACT_START) || !out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_move;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_act_r <= in_ch.action;
      s1_yaw_r <= in_ch.yaw;
      s1_ang_r <= in_ch.turn_angle;
      s1_now_r <= in_ch.now_ms;
    end
  end

  // ---------------- controller state ----------------
  ytc_pkg::angle_t target_r, target_nxt;
  logic            waiting_r, waiting_nxt;
  logic            correcting_r, correcting_nxt;
  logic [31:0]     wait_start_r, wait_start_nxt;

  ytc_pkg::angle_t err;
  logic [11:0]     err_mag;
  logic            in_tol;
  logic [31:0]     elapsed;
  logic            pausing;
  ytc_pkg::drive_t calc_drive;
  ytc_pkg::drive_t res_drive;
  logic            res_done;

  ytc_drive_calc u_drive (
    .err       (err),
    .gain      (gain_r),
    .max_drive (max_drive_r),
    .min_drive (min_drive_r),
    .drive     (calc_drive)
  );

  always_comb begin
    err     = ytc_pkg::wrap_angle(ytc_pkg::wide_t'(target_r) - ytc_pkg::wide_t'(s1_yaw_r));
    err_mag = err[12] ? 12'(-err) : err[11:0];
    in_tol  = err_mag <= tolerance_r;
    // modulo 2^32 elapsed time, so timestamp wrap is harmless
    elapsed = s1_now_r - wait_start_r;
    pausing = elapsed < {16'b0, wait_ms_r};

    target_nxt     = target_r;
    waiting_nxt    = waiting_r;
    correcting_nxt = correcting_r;
    wait_start_nxt = wait_start_r;
    res_drive      = '0;
    res_done       = 1'b0;

    if (s1_act_r == ytc_pkg::ACT_START) begin
      target_nxt     = ytc_pkg::wrap_angle(ytc_pkg::wide_t'(s1_yaw_r)
                                           + ytc_pkg::wide_t'(s1_ang_r));
      waiting_nxt    = 1'b0;
      correcting_nxt = 1'b0;
      wait_start_nxt = '0;
    end else if (in_tol) begin
      waiting_nxt    = 1'b0;
      correcting_nxt = 1'b0;
      res_done       = 1'b1;
    end else if (!waiting_r && !correcting_r) begin
      // first miss: stop and start the settling pause
      waiting_nxt    = 1'b1;
      wait_start_nxt = s1_now_r;
    end else if (waiting_r && pausing) begin
      res_drive = '0;
    end else begin
      // pause over (or already correcting): drive this request
      waiting_nxt    = 1'b0;
      correcting_nxt = 1'b1;
      res_drive      = calc_drive;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= '0;
      waiting_r    <= 1'b0;
      correcting_r <= 1'b0;
      wait_start_r <= '0;
    end else if (s1_move) begin
      target_r     <= target_nxt;
      waiting_r    <= waiting_nxt;
      correcting_r <= correcting_nxt;
      wait_start_r <= wait_start_nxt;
    end
  end

  // ---------------- result register ----------------
  logic            out_load;
  ytc_pkg::drive_t out_left_r;
  ytc_pkg::drive_t out_right_r;
  logic            out_done_r;

  assign out_load = s1_move && (s1_act_r == ytc_pkg::ACT_UPDATE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= -res_drive;
      out_right_r <= res_drive;
      out_done_r  <= res_done;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.left_drive  = out_left_r;
  assign out_ch.right_drive = out_right_r;
  assign out_ch.done_res    = out_done_r;

  // ---------------- assertions ----------------
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(waiting_r && correcting_r))
    else $error("waiting and correcting both set");

  a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && (s1_act_r == ytc_pkg::ACT_START) && !out_v_r) |=> !out_v_r)
    else $error("start request produced a result");

  a_done_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_done_r) |-> (out_right_r == '0 && out_left_r == '0))
    else $error("finished result with nonzero drive");

  a_mirror_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_left_r == ytc_pkg::drive_t'(-out_right_r)))
    else $error("left drive is not the mirror of right drive");

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for yaw_turn_controller, driving random and directed
// requests through ytc_in_if and scoreboarding ytc_out_if against a behavioral predictor.
// Depends on ytc_pkg, ytc_in_if, ytc_out_if and the controller RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int TURN_FULL = 5760;
  localparam int TURN_HALF = 2880;
  localparam int CYC_LIMIT = 400000;
  localparam int N_PHASES  = 9;
  localparam int N_RANDOM  = 112;     // random requests per register setting
  localparam int DRAIN_CYC = 8;

  typedef struct {
    logic            action;
    ytc_pkg::angle_t yaw;
    ytc_pkg::turn_t  turn_angle;
    logic [31:0]     now_ms;
  } turn_req_t;

  typedef struct {
    ytc_pkg::drive_t left;
    ytc_pkg::drive_t right;
    logic            done;
  } drive_cmd_t;

  logic clk;
  logic rst_n;
  logic                           cfg_we;
  logic [ytc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ytc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ytc_in_if  in_ch ();
  ytc_out_if out_ch ();

  yaw_turn_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Request stream waiting for the driver, and commands still owed by the DUT.
  turn_req_t  req_pending[$];
  drive_cmd_t cmd_expected[$];

  // Predictor copy of the register file (loaded with the reset defaults).
  int cfg_tol       = ytc_pkg::TOLERANCE_RST;
  int cfg_wait_ms   = ytc_pkg::WAIT_MS_RST;
  int cfg_gain      = ytc_pkg::GAIN_RST;
  int cfg_max_drive = ytc_pkg::MAX_DRIVE_RST;
  int cfg_min_drive = ytc_pkg::MIN_DRIVE_RST;

  // Predictor copy of the heading state.
  int          tgt_yaw    = 0;
  logic        is_waiting = 1'b0;
  logic        is_correct = 1'b0;
  logic [31:0] wait_t0    = '0;

  // Idle knobs, percent of cycles.
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  int   cyc_cnt   = 0;
  int   n_queued  = 0;
  int   n_taken   = 0;
  int   n_starts  = 0;
  int   n_checked = 0;
  int   n_done    = 0;
  int   n_driven  = 0;
  int   n_fail    = 0;
  logic req_taken = 1'b0;

  // Stimulus shaping: the generator tracks the heading it asked for.
  int          gen_target = 0;
  logic [31:0] gen_now    = '0;
  int          seq_left   = 0;

  // ---------------------------------------------------------------------
  // Clock, reset and a known value on every DUT input from time zero
  // ---------------------------------------------------------------------
  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ytc_pkg::ACT_START;
    in_ch.yaw        = '0;
    in_ch.turn_angle = '0;
    in_ch.now_ms     = '0;
    out_ch.ready     = 1'b0;
    forever #5 clk = ~clk;
  end

  // Wrap into [-180, 180) degrees, i.e. [-2880, 2880) in 1/16 degree.
  function automatic int wrap_heading(input int v);
    int r;
    r = (v + TURN_HALF) % TURN_FULL;
    if (r < 0)
      r += TURN_FULL;
    return r - TURN_HALF;
  endfunction

  // ---------------------------------------------------------------------
  // Heading predictor: one accepted request in, zero or one command owed
  // ---------------------------------------------------------------------
  task automatic predict_turn(input turn_req_t r);
    int         err;
    int         mag;
    int         drv;
    drive_cmd_t c;
    if (r.action == ytc_pkg::ACT_START) begin
      // new target relative to the current yaw; no command comes back
      tgt_yaw    = wrap_heading(int'(r.yaw) + int'(r.turn_angle));
      is_waiting = 1'b0;
      is_correct = 1'b0;
      wait_t0    = '0;
      n_starts++;
      return;
    end
    err = wrap_heading(tgt_yaw - int'(r.yaw));
    mag = (err < 0) ? -err : err;
    drv = 0;
    c.done = 1'b0;
    if (mag <= cfg_tol) begin
      // on heading: finished, motors off, flags clear
      is_waiting = 1'b0;
      is_correct = 1'b0;
      c.done = 1'b1;
      n_done++;
    end else if (!is_waiting && !is_correct) begin
      // first miss starts the settling pause
      is_waiting = 1'b1;
      wait_t0    = r.now_ms;
    end else if (is_waiting && (32'(r.now_ms - wait_t0) < 32'(cfg_wait_ms))) begin
      // still settling, elapsed time taken modulo 2^32
    end else begin
      is_waiting = 1'b0;
      is_correct = 1'b1;
      drv = (cfg_gain * err) / 256;  // truncates toward zero
      if (drv > cfg_max_drive)
        drv = cfg_max_drive;
      if (drv < -cfg_max_drive)
        drv = -cfg_max_drive;
      // friction floor wins over the clamp; sign follows the error
      if (((drv < 0) ? -drv : drv) < cfg_min_drive)
        drv = (err > 0) ? cfg_min_drive : -cfg_min_drive;
      n_driven++;
    end
    c.right = ytc_pkg::drive_t'(drv);
    c.left  = ytc_pkg::drive_t'(-drv);
    cmd_expected.push_back(c);
  endtask

  // ---------------------------------------------------------------------
  // Driver: inputs move on the falling edge; a request holds until taken
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    turn_req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || req_taken) begin
      if (req_pending.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        nxt = req_pending.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.action     <= nxt.action;
        in_ch.yaw        <= nxt.yaw;
        in_ch.turn_angle <= nxt.turn_angle;
        in_ch.now_ms     <= nxt.now_ms;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // ---------------------------------------------------------------------
  // Monitor: sample both channels on the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    turn_req_t  r;
    drive_cmd_t got;
    drive_cmd_t exp_cmd;
    cyc_cnt   <= cyc_cnt + 1;
    req_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      r.action     = in_ch.action;
      r.yaw        = in_ch.yaw;
      r.turn_angle = in_ch.turn_angle;
      r.now_ms     = in_ch.now_ms;
      predict_turn(r);
      n_taken++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.left  = out_ch.left_drive;
      got.right = out_ch.right_drive;
      got.done  = out_ch.done_res;
      if (cmd_expected.size() == 0) begin
        $display("%0t unexpected result: got L=%0d R=%0d done=%0b",
                 $time, got.left, got.right, got.done);
        n_fail++;
      end else begin
        exp_cmd = cmd_expected.pop_front();
        if (got.left !== exp_cmd.left || got.right !== exp_cmd.right ||
            got.done !== exp_cmd.done) begin
          $display("%0t mismatch: expected L=%0d R=%0d done=%0b, got L=%0d R=%0d done=%0b",
                   $time, exp_cmd.left, exp_cmd.right, exp_cmd.done,
                   got.left, got.right, got.done);
          n_fail++;
        end
        n_checked++;
      end
    end
  end

  // Watchdog on the cycle counter
  initial begin
    wait (cyc_cnt >= CYC_LIMIT);
    $display("timeout after %0d cycles, %0d results still owed", cyc_cnt, cmd_expected.size());
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic queue_req(input logic act, input int yaw, input int ang,
                           input logic [31:0] now);
    turn_req_t r;
    r.action     = act;
    r.yaw        = ytc_pkg::angle_t'(yaw);
    r.turn_angle = ytc_pkg::turn_t'(ang);
    r.now_ms     = now;
    req_pending.push_back(r);
    n_queued++;
  endtask

  // Back-to-back register writes, one per falling edge; the block is idle.
  task automatic load_regs(input int tol, input int wt, input int gn, input int mx,
                           input int mn);
    logic [ytc_pkg::CFG_IDX_W-1:0] idx;
    int                            val;
    for (int i = 0; i < 5; i++) begin
      case (i)
        0: begin idx = ytc_pkg::REG_TOLERANCE; val = tol; cfg_tol       = tol; end
        1: begin idx = ytc_pkg::REG_WAIT_MS;   val = wt;  cfg_wait_ms   = wt;  end
        2: begin idx = ytc_pkg::REG_GAIN;      val = gn;  cfg_gain      = gn;  end
        3: begin idx = ytc_pkg::REG_MAX_DRIVE; val = mx;  cfg_max_drive = mx;  end
        default: begin idx = ytc_pkg::REG_MIN_DRIVE; val = mn; cfg_min_drive = mn; end
      endcase
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= ytc_pkg::CFG_DATA_W'(val);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued request is taken and every command has come
  // back, then give a trailing start request time to leave the pipeline.
  task automatic drain_all();
    while (n_taken != n_queued || cmd_expected.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  // Mostly well-formed turns: a start, then a run of updates whose yaw
  // sits a shaped distance off the target and whose clock creeps forward
  // at a pace tied to wait_ms. The rest is unconstrained noise.
  task automatic gen_random(input int n);
    int pick;
    int yaw;
    int ang;
    int off;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_req($urandom_range(0, 1), $urandom_range(0, 8191) - 4096,
                  $urandom_range(0, 16383) - 8192, $urandom);
      end else if (pick < 18 || seq_left == 0) begin
        yaw = $urandom_range(0, 5759) - TURN_HALF;
        ang = $urandom_range(0, 11520) - TURN_FULL;
        gen_target = wrap_heading(yaw + ang);
        gen_now    = $urandom;
        seq_left   = $urandom_range(3, 15);
        queue_req(ytc_pkg::ACT_START, yaw, ang, $urandom);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 30)
          off = $urandom_range(0, (cfg_tol > TURN_HALF) ? TURN_HALF : cfg_tol);
        else if (pick < 70)
          off = $urandom_range(0, 400);
        else
          off = $urandom_range(0, TURN_HALF);
        if ($urandom_range(0, 1))
          off = -off;
        yaw = wrap_heading(gen_target - off);
        // now and then report the same heading one turn out of range
        if (yaw + TURN_FULL <= 4095 && $urandom_range(0, 9) == 0)
          yaw += TURN_FULL;
        else if (yaw - TURN_FULL >= -4096 && $urandom_range(0, 9) == 0)
          yaw -= TURN_FULL;
        pick = $urandom_range(0, 99);
        if (pick < 85)
          gen_now += $urandom_range(0, cfg_wait_ms / 4 + 50);
        else if (pick < 97)
          gen_now += $urandom_range(0, cfg_wait_ms * 2 + 100);
        else
          gen_now = $urandom;
        queue_req(ytc_pkg::ACT_UPDATE, yaw, $urandom_range(0, 16383) - 8192, gen_now);
        seq_left--;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // idle profile: receiver-heavy stalls, then sender-heavy gaps, then none
      if (ph < 3) begin
        src_idle_pct  = 11;
        snk_stall_pct = 82;
      end else if (ph < 6) begin
        src_idle_pct  = 82;
        snk_stall_pct = 11;
      end else begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end

      case (ph)
        0: ; // reset defaults
        1: load_regs(0, 0, 255, 255, 0);          // tightest, no pause, full gain
        2: load_regs(2880, 65535, 0, 0, 255);     // tolerance at a half turn, longest pause
        3: load_regs(16, 100, 40, 60, 200);       // friction floor above the clamp
        4: load_regs(4095, 300, 128, 255, 0);     // tolerance covers every error
        5: load_regs(64, 65535, 128, 255, 0);     // long pause, clock wrap matters
        6: load_regs(0, 10, 1, 255, 0);           // tiny gain: zero drive stays zero
        default: load_regs($urandom_range(0, 2880), $urandom_range(0, 3000),
                           $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
      endcase

      if (ph == 0) begin
        // hand-picked walk through the controller at reset settings
        queue_req(ytc_pkg::ACT_START, 0, 0, 0);
        queue_req(ytc_pkg::ACT_UPDATE, 32, 0, 5);      // error at the tolerance edge
        queue_req(ytc_pkg::ACT_UPDATE, -33, 0, 10);    // first miss, pause begins
        queue_req(ytc_pkg::ACT_UPDATE, -33, 0, 2009);  // one ms short of the pause
        queue_req(ytc_pkg::ACT_UPDATE, -33, 0, 2010);  // pause over, floor raises drive
        queue_req(ytc_pkg::ACT_UPDATE, 2000, 0, 0);    // large negative error, clamped
        queue_req(ytc_pkg::ACT_UPDATE, -2879, 0, 1);
        queue_req(ytc_pkg::ACT_UPDATE, 2879, 0, 2);
        queue_req(ytc_pkg::ACT_START, 2879, 5760, 3);  // target lands on +179.9375 deg
        queue_req(ytc_pkg::ACT_UPDATE, -2880, 0, 4);   // error wraps across +-180
        queue_req(ytc_pkg::ACT_START, -4096, -8192, 5);  // most negative field values
        queue_req(ytc_pkg::ACT_START, 4095, 8191, 6);    // most positive field values
        queue_req(ytc_pkg::ACT_UPDATE, -4096, 0, 32'hFFFF_FF00);
        queue_req(ytc_pkg::ACT_UPDATE, 4095, 0, 32'h0000_0100);  // clock wrapped, paused
        queue_req(ytc_pkg::ACT_UPDATE, 4095, 0, 32'h0000_0800);  // wrapped time ends pause
        queue_req(ytc_pkg::ACT_UPDATE, 4095, 0, 32'hFFFF_FFFF);
        queue_req(ytc_pkg::ACT_START, 100, -5760, 0);  // a full turn lands on yaw
        queue_req(ytc_pkg::ACT_UPDATE, -2000, 0, 7);   // flags were cleared: fresh miss
        queue_req(ytc_pkg::ACT_UPDATE, 100, 0, 8);     // back on heading
        queue_req(ytc_pkg::ACT_UPDATE, 0, 0, 50);      // miss after finish re-arms pause
        queue_req(ytc_pkg::ACT_UPDATE, 0, 8191, 60);   // angle ignored on update
      end
      gen_random(N_RANDOM);
      drain_all();
    end

    repeat (DRAIN_CYC) @(negedge clk);
    if (cmd_expected.size() != 0) begin
      $display("%0t %0d results never arrived", $time, cmd_expected.size());
      n_fail++;
    end
    $display("Covered %0d requests (%0d turn starts) over %0d register settings;",
             n_taken, n_starts, N_PHASES);
    $display("checked %0d commands: %0d finished, %0d driven, %0d errors.",
             n_checked, n_done, n_driven, n_fail);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
